/* rtl/core/ncce_pkg.sv */
// Shared constants, codes and controller/datapath types of the concept enumerator.
`default_nettype none
package ncce_pkg;

  localparam int unsigned MAX_OBJECTS_DEF    = 32;
  localparam int unsigned MAX_ATTRIBUTES_DEF = 32;

  localparam int unsigned ROW_W   = 32;  // stored row width
  localparam int unsigned CFG_W   = 6;   // widest configuration register
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_OBJECTS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ATTRIBUTES = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic scan_init;   // load position with highest object
    logic pos_dec;     // step to the next lower position
    logic close_init;  // set up candidate set, intent and extent
    logic first;       // candidate is the empty set
    logic ext_init;    // restart sweep for the extent pass
    logic sweep;       // walk the rows
    logic ext_phase;   // 0: intent pass, 1: extent pass
    logic commit;      // take closure as the next concept
    logic fail;        // emit the exhausted answer
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pos_in_cur;
    logic pos_zero;
    logic sweep_done;
    logic match;
    logic full;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/ncce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ncce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ncce_ctrl.sv */
// Controller state machine of the concept enumerator.
`default_nettype none
module ncce_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_accept_i,
  input  wire logic              req_kind_i,
  input  wire ncce_pkg::status_t st_i,
  output ncce_pkg::cmd_t         cmd_o,
  output logic                   ready_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_INTENT  = 6'b000100,
    ST_EXTENT  = 6'b001000,
    ST_CHECK   = 6'b010000,
    ST_EXHAUST = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   finished_q, finished_d;
  logic   first_q, first_d;

  assign ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    started_d  = started_q;
    finished_d = finished_q;
    first_d    = first_q;
    cmd_o      = '0;
    cmd_o.first = first_q;
    case (state_q)
      ST_IDLE: begin
        if (req_accept_i && (req_kind_i == ncce_pkg::KIND_NEXT)) begin
          if (finished_q) begin
            state_d = ST_EXHAUST;
          end else if (!started_q) begin
            first_d          = 1'b1;
            cmd_o.first      = 1'b1;
            cmd_o.close_init = 1'b1;
            state_d          = ST_INTENT;
          end else begin
            first_d         = 1'b0;
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // skip positions already in the extent
        if (st_i.pos_in_cur) begin
          if (st_i.pos_zero) begin
            state_d = ST_EXHAUST;
          end else begin
            cmd_o.pos_dec = 1'b1;
          end
        end else begin
          cmd_o.close_init = 1'b1;
          state_d          = ST_INTENT;
        end
      end
      ST_INTENT: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_done) begin
          cmd_o.ext_init = 1'b1;
          state_d        = ST_EXTENT;
        end
      end
      ST_EXTENT: begin
        cmd_o.sweep     = 1'b1;
        cmd_o.ext_phase = 1'b1;
        if (st_i.sweep_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (first_q || st_i.match) begin
          if (st_i.out_free) begin
            cmd_o.commit = 1'b1;
            started_d    = 1'b1;
            finished_d   = finished_q | st_i.full;
            state_d      = ST_IDLE;
          end
        end else if (st_i.pos_zero) begin
          state_d = ST_EXHAUST;
        end else begin
          cmd_o.pos_dec = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_EXHAUST: begin
        if (st_i.out_free) begin
          cmd_o.fail = 1'b1;
          finished_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      started_q  <= started_d;
      finished_q <= finished_d;
      first_q    <= first_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ncce_dpath.sv */
// Datapath: configuration, closure sweeps over the rows, current extent, result register.
`default_nettype none
module ncce_dpath #(
  parameter int unsigned MAX_OBJECTS    = ncce_pkg::MAX_OBJECTS_DEF,
  parameter int unsigned MAX_ATTRIBUTES = ncce_pkg::MAX_ATTRIBUTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ncce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ncce_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire ncce_pkg::cmd_t                    cmd_i,
  output ncce_pkg::status_t                      st_o,
  output logic                                   ram_re_o,
  output logic [$clog2(MAX_OBJECTS)-1:0]         ram_raddr_o,
  input  wire logic [ncce_pkg::ROW_W-1:0]        ram_rdata_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [31:0]                            out_extent_o,
  output logic [31:0]                            out_intent_o,
  output logic                                   out_last_o,
  output logic                                   out_exhausted_o
);

  localparam int unsigned OBJ_W  = MAX_OBJECTS;
  localparam int unsigned ATTR_W = MAX_ATTRIBUTES;
  localparam int unsigned IDX_W  = $clog2(MAX_OBJECTS);
  localparam int unsigned CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned ACNT_W = $clog2(MAX_ATTRIBUTES + 1);
  localparam logic [CNT_W-1:0]  ObjRst  = CNT_W'(MAX_OBJECTS < 32 ? MAX_OBJECTS : 32);
  localparam logic [ACNT_W-1:0] AttrRst = ACNT_W'(MAX_ATTRIBUTES < 32 ? MAX_ATTRIBUTES : 32);
  localparam logic [ncce_pkg::CFG_W:0] MaxObjX  = (ncce_pkg::CFG_W + 1)'(MAX_OBJECTS);
  localparam logic [ncce_pkg::CFG_W:0] MaxAttrX = (ncce_pkg::CFG_W + 1)'(MAX_ATTRIBUTES);

  logic [CNT_W-1:0]  nobj_q;
  logic [ACNT_W-1:0] nattr_q;
  logic [CNT_W-1:0]  obj_cl;
  logic [ACNT_W-1:0] attr_cl;
  logic [ncce_pkg::CFG_W:0] val_x;

  logic [OBJ_W-1:0]  cur_ext_q;
  logic [OBJ_W-1:0]  omask, below, cur, lower;
  logic [ATTR_W-1:0] amask;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [OBJ_W-1:0]  cand_q, cand_d;
  logic [ATTR_W-1:0] intent_q, intent_d;
  logic [OBJ_W-1:0]  ext_q, ext_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_j_q;
  logic              issue;
  logic [ATTR_W-1:0] row_a;

  // Clamp register writes into 1..MAX.
  always_comb begin
    val_x = {1'b0, cfg_data_i};
    if (cfg_data_i == '0) begin
      obj_cl  = CNT_W'(1);
      attr_cl = ACNT_W'(1);
    end else begin
      obj_cl  = (val_x > MaxObjX)  ? CNT_W'(MAX_OBJECTS)     : CNT_W'(cfg_data_i);
      attr_cl = (val_x > MaxAttrX) ? ACNT_W'(MAX_ATTRIBUTES) : ACNT_W'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nobj_q  <= ObjRst;
      nattr_q <= AttrRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ncce_pkg::REG_NUM_OBJECTS) begin
        nobj_q <= obj_cl;
      end
      if (cfg_index_i == ncce_pkg::REG_NUM_ATTRIBUTES) begin
        nattr_q <= attr_cl;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < int'(OBJ_W); b++) begin
      omask[b] = (b < int'(nobj_q));
      below[b] = (b < int'(pos_q));
    end
    for (int k = 0; k < int'(ATTR_W); k++) begin
      amask[k] = (k < int'(nattr_q));
    end
  end

  assign cur   = cur_ext_q & omask;
  assign lower = cur & below;
  assign row_a = ATTR_W'(ram_rdata_i);

  assign issue       = cmd_i.sweep && (j_q < nobj_q);
  assign ram_re_o    = issue;
  assign ram_raddr_o = j_q[IDX_W-1:0];

  always_comb begin
    pos_d    = pos_q;
    cand_d   = cand_q;
    intent_d = intent_q;
    ext_d    = ext_q;
    j_d      = j_q;
    if (cmd_i.scan_init) begin
      pos_d = IDX_W'(nobj_q - CNT_W'(1));
    end
    if (cmd_i.pos_dec) begin
      pos_d = pos_q - IDX_W'(1);
    end
    if (rd_vld_q) begin
      if (!cmd_i.ext_phase) begin
        if (cand_q[rd_j_q]) begin
          intent_d = intent_q & row_a;
        end
      end else if ((row_a & intent_q) == intent_q) begin
        ext_d[rd_j_q] = 1'b1;
      end
    end
    if (issue) begin
      j_d = j_q + CNT_W'(1);
    end
    if (cmd_i.close_init) begin
      cand_d   = cmd_i.first ? '0 : (lower | (OBJ_W'(1) << pos_q));
      intent_d = amask;
      ext_d    = '0;
      j_d      = '0;
    end
    if (cmd_i.ext_init) begin
      j_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cand_q   <= cand_d;
    intent_q <= intent_d;
    ext_q    <= ext_d;
    j_q      <= j_d;
    rd_j_q   <= j_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      cur_ext_q <= '0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.commit) begin
        cur_ext_q <= ext_q;
      end
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit || cmd_i.fail) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_extent_o    <= 32'(ext_q);
      out_intent_o    <= 32'(intent_q);
      out_last_o      <= (ext_q == omask);
      out_exhausted_o <= 1'b0;
    end else if (cmd_i.fail) begin
      out_extent_o    <= '0;
      out_intent_o    <= '0;
      out_last_o      <= 1'b0;
      out_exhausted_o <= 1'b1;
    end
  end

  always_comb begin
    st_o            = '0;
    st_o.pos_in_cur = cur[pos_q];
    st_o.pos_zero   = (pos_q == '0);
    st_o.sweep_done = (j_q == nobj_q) && !rd_vld_q;
    st_o.match      = ((ext_q & below) == lower);
    st_o.full       = (ext_q == omask);
    st_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

/* rtl/core/next_closure_concept_enumerator_top.sv */
// Top level of the next-closure formal concept enumerator.
//
//  Port group  Dir  Carries
//  s_axis_*    in   requests: tuser = kind, tdata = row_index, row_bits
//  m_axis_*    out  concepts: tdata = extent, intent_bits; tlast = is_last;
//                   tuser = exhausted
//  cfg_*       in   register writes: num_objects, num_attributes
//
// A load's row is written into the row RAM on acceptance.
// A next request closes one candidate set per tried position: each closure is
// two sweeps over the row RAM at one read a cycle, followed by a check, and
// the scan state steps past each position already in the current extent.
// Reset clears the enumeration state and sets both registers to 32 (clamped).
// The result register frees the input side; a request that finds it still
// occupied waits at the end of its search until the result is taken.
`default_nettype none
module next_closure_concept_enumerator_top #(
  parameter int unsigned MAX_OBJECTS    = ncce_pkg::MAX_OBJECTS_DEF,
  parameter int unsigned MAX_ATTRIBUTES = ncce_pkg::MAX_ATTRIBUTES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ncce_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // row_index[4:0], row_bits[36:5]
  input  wire logic                               s_axis_tuser,  // kind
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [ncce_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // extent[31:0], intent_bits[63:32]
  output logic                                    m_axis_tlast,
  output logic                                    m_axis_tuser,  // exhausted
  input  wire logic                               cfg_we_i,
  input  wire logic [ncce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ncce_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_OBJECTS);

  ncce_pkg::cmd_t    cmd;
  ncce_pkg::status_t st;
  logic                         accept;
  logic [4:0]                   row_index;
  logic [ncce_pkg::ROW_W-1:0]   row_bits;
  logic                         ram_we;
  logic                         ram_re;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ncce_pkg::ROW_W-1:0]   ram_rdata;
  logic [31:0]                  out_extent;
  logic [31:0]                  out_intent;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign row_index = s_axis_tdata[4:0];
  assign row_bits  = s_axis_tdata[36:5];
  // drop loads beyond the row store
  assign ram_we    = accept && (s_axis_tuser == ncce_pkg::KIND_LOAD)
                     && (32'(row_index) < MAX_OBJECTS);

  ncce_ram #(
    .WIDTH (ncce_pkg::ROW_W),
    .DEPTH (MAX_OBJECTS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(row_index)),
    .wdata_i (row_bits),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ncce_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_accept_i (accept),
    .req_kind_i   (s_axis_tuser),
    .st_i         (st),
    .cmd_o        (cmd),
    .ready_o      (s_axis_tready)
  );

  ncce_dpath #(
    .MAX_OBJECTS    (MAX_OBJECTS),
    .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_extent_o    (out_extent),
    .out_intent_o    (out_intent),
    .out_last_o      (m_axis_tlast),
    .out_exhausted_o (m_axis_tuser)
  );

  assign m_axis_tdata = {out_intent, out_extent};

endmodule
`default_nettype wire
